### hdl/scba_pkg.sv
// Shared field widths, codes and state encoding for the size class block allocator.
`timescale 1ns / 1ps
`default_nettype none
package scba_pkg;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 17;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 14;

  localparam logic [LIVE_W-1:0] TALLY_MAX = 14'h3FFF;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_OVERSIZE  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_CARVE,
    S_FETCH,
    S_POP,
    S_DONE
  } state_e_t;

endpackage
`default_nettype wire

### hdl/scba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/scba_cdiv.sv
// Unsigned division by a constant through multiplication with a rounded-up reciprocal.
`timescale 1ns / 1ps
`default_nettype none
module scba_cdiv #(
  parameter int DIVISOR = 16,
  parameter int IN_W    = 16,
  parameter int OUT_W   = 16
) (
  input  wire logic [IN_W-1:0]  a,
  output logic      [OUT_W-1:0] q
);

  // With the shift set to the input width plus the ceiling log2 of the divisor, the
  // rounded-up reciprocal gives the exact floor for every input value.
  localparam int              LOG_D = $clog2(DIVISOR);
  localparam int              SH    = IN_W + LOG_D;
  localparam int              MW    = IN_W + 2;
  localparam int              PW    = IN_W + MW;
  localparam longint unsigned MUL   = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;

  logic [PW-1:0] prod;

  assign prod = PW'(a) * PW'(MUL);
  assign q    = OUT_W'(prod >> SH);

endmodule
`default_nettype wire

### hdl/size_class_block_allocator.sv
// Top level of the size class block allocator: request sequencer and state memories.
`timescale 1ns / 1ps
`default_nettype none
// Each request allocates a block, frees one, clears the pool or does nothing, and yields exactly one
// result. Sizes are rounded up to a multiple of UNIT_BYTES to pick a class; each class
// keeps a singly linked free list whose heads sit in a small RAM and whose links sit
// in a RAM with one entry per unit of the pool. A free, a clear and any refused request
// finish in the head lookup; an allocate from a non-empty list reads the head RAM and
// then the link RAM, both with registered reads. An allocate to an empty class carves
// a fresh chunk, writing one link per cycle, then fetches and pops its first block.
// When the previous result is still waiting to be taken, the new result is parked
// until the receiver has accepted the waiting one.
// A new request is taken only when the previous one has finished its memory
// work. Link entries are undefined until written; no clearing pass is needed.
module size_class_block_allocator #(
  parameter int UNIT_BYTES   = 16,
  parameter int SIZE_CLASSES = 16,
  parameter int CHUNK_BYTES  = 16384,
  parameter int POOL_CHUNKS  = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [scba_pkg::OP_W-1:0]      in_op,
  input  wire logic [scba_pkg::SIZE_W-1:0]    in_size,
  input  wire logic [scba_pkg::ADDR_W-1:0]    in_address,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [scba_pkg::ADDR_W-1:0]    out_address_out,
  output logic      [scba_pkg::STATUS_W-1:0]  out_status,
  output logic      [scba_pkg::LIVE_W-1:0]    out_live_blocks
);

  import scba_pkg::*;

  localparam int POOL_BYTES = CHUNK_BYTES * POOL_CHUNKS;
  localparam int MAX_BLOCK  = UNIT_BYTES * SIZE_CLASSES;
  localparam int AW         = $clog2(POOL_BYTES + 1);
  localparam int EW         = AW + 1;
  localparam int SLOT_DEPTH = (POOL_BYTES - 1) / UNIT_BYTES + 1;
  localparam int SW         = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CLS_W      = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int BW         = $clog2(MAX_BLOCK + 1);
  localparam int CKW        = $clog2(POOL_CHUNKS + 1);

  localparam logic [AW-1:0] NIL_ADDR = AW'(POOL_BYTES);

  // Control state.
  state_e_t                 state_r, state_nxt;
  logic [SIZE_CLASSES-1:0]  valid_r, valid_nxt;
  logic [CKW-1:0]           chunks_r, chunks_nxt;
  logic [LIVE_W-1:0]        tally_r, tally_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Request and result payload.
  op_e_t                    op_r, op_nxt;
  logic [CLS_W-1:0]         cls_r, cls_nxt;
  logic                     zero_r, zero_nxt;
  logic                     over_r, over_nxt;
  logic                     free_ok_r, free_ok_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            blk_r, blk_nxt;
  logic [BW-1:0]            bsize_r, bsize_nxt;
  logic [AW-1:0]            carve_a_r, carve_a_nxt;
  logic [AW-1:0]            chunk_end_r, chunk_end_nxt;
  logic [ADDR_W-1:0]        res_addr_r, res_addr_nxt;
  status_e_t                res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]        out_addr_r, out_addr_nxt;
  status_e_t                out_status_r, out_status_nxt;
  logic [LIVE_W-1:0]        out_live_r, out_live_nxt;

  // Memory ports and datapath.
  logic [CLS_W-1:0]         cls_in;
  logic [AW-1:0]            head_rd;
  logic                     head_we;
  logic [AW-1:0]            head_wdata;
  logic [AW-1:0]            link_rd;
  logic                     link_we;
  logic [AW-1:0]            link_wdata;
  logic [AW-1:0]            slot_src;
  logic [SW-1:0]            slot;
  logic [AW-1:0]            head;
  logic [BW-1:0]            bsize;
  logic [AW-1:0]            base;
  logic                     carve_ok;
  logic [AW-1:0]            carve_step;
  logic                     carve_last;
  logic                     out_free;
  logic                     fin;
  logic [ADDR_W-1:0]        fin_addr;
  status_e_t                fin_status;

  scba_cdiv #(
    .DIVISOR (UNIT_BYTES),
    .IN_W    (SIZE_W),
    .OUT_W   (CLS_W)
  ) u_cls_div (
    .a (in_size - SIZE_W'(1)),
    .q (cls_in)
  );

  scba_cdiv #(
    .DIVISOR (UNIT_BYTES),
    .IN_W    (AW),
    .OUT_W   (SW)
  ) u_slot_div (
    .a (slot_src),
    .q (slot)
  );

  scba_ram #(
    .WIDTH (AW),
    .DEPTH (SIZE_CLASSES),
    .AW    (CLS_W)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (cls_r),
    .wdata (head_wdata),
    .raddr (cls_in),
    .rdata (head_rd)
  );

  scba_ram #(
    .WIDTH (AW),
    .DEPTH (SLOT_DEPTH),
    .AW    (SW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (slot),
    .wdata (link_wdata),
    .raddr (slot),
    .rdata (link_rd)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_address_out = out_addr_r;
  assign out_status      = out_status_r;
  assign out_live_blocks = out_live_r;

  assign out_free   = !out_valid_r || out_ready;
  assign head       = valid_r[cls_r] ? head_rd : NIL_ADDR;
  assign bsize      = BW'((32'(cls_r) + 32'd1) * UNIT_BYTES);
  assign base       = AW'(32'(chunks_r) * CHUNK_BYTES);
  assign carve_ok   = (32'(bsize) <= CHUNK_BYTES) && (chunks_r < CKW'(POOL_CHUNKS));
  assign carve_step = carve_a_r + AW'(bsize_r);
  // The current block is the last of its chunk when a further block would not fit.
  assign carve_last = (EW'(carve_step) + EW'(bsize_r)) > EW'(chunk_end_r);

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    chunks_nxt     = chunks_r;
    tally_nxt      = tally_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    cls_nxt        = cls_r;
    zero_nxt       = zero_r;
    over_nxt       = over_r;
    free_ok_nxt    = free_ok_r;
    addr_nxt       = addr_r;
    blk_nxt        = blk_r;
    bsize_nxt      = bsize_r;
    carve_a_nxt    = carve_a_r;
    chunk_end_nxt  = chunk_end_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_live_nxt   = out_live_r;
    head_we        = 1'b0;
    head_wdata     = '0;
    link_we        = 1'b0;
    link_wdata     = '0;
    slot_src       = blk_r;
    fin            = 1'b0;
    fin_addr       = '0;
    fin_status     = ST_OK;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = op_e_t'(in_op);
          cls_nxt     = cls_in;
          zero_nxt    = (in_size == '0);
          over_nxt    = (32'(in_size) > MAX_BLOCK);
          free_ok_nxt = (32'(in_address) < POOL_BYTES);
          addr_nxt    = AW'(in_address);
          state_nxt   = S_HEAD;
        end
      end
      S_HEAD: begin
        if (op_r == OP_CLEAR) begin
          valid_nxt  = '0;
          chunks_nxt = '0;
          tally_nxt  = '0;
          fin        = 1'b1;
        end else if (op_r == OP_NOP) begin
          fin = 1'b1;
        end else if (zero_r) begin
          fin        = 1'b1;
          fin_status = ST_NULL;
        end else if (over_r) begin
          fin        = 1'b1;
          fin_status = ST_OVERSIZE;
        end else if (op_r == OP_ALLOC) begin
          if (head != NIL_ADDR) begin
            slot_src  = head;
            blk_nxt   = head;
            state_nxt = S_POP;
          end else if (carve_ok) begin
            blk_nxt       = base;
            carve_a_nxt   = base;
            chunk_end_nxt = base + AW'(CHUNK_BYTES);
            bsize_nxt     = bsize;
            state_nxt     = S_CARVE;
          end else begin
            fin        = 1'b1;
            fin_status = ST_EXHAUSTED;
          end
        end else begin
          // Free: push the block onto its class list; out-of-pool addresses are ignored.
          if (free_ok_r) begin
            slot_src          = addr_r;
            link_we           = 1'b1;
            link_wdata        = head;
            head_we           = 1'b1;
            head_wdata        = addr_r;
            valid_nxt[cls_r]  = 1'b1;
            if (tally_r != '0) begin
              tally_nxt = tally_r - LIVE_W'(1);
            end
          end
          fin = 1'b1;
        end
      end
      S_CARVE: begin
        slot_src    = carve_a_r;
        link_we     = 1'b1;
        link_wdata  = carve_last ? NIL_ADDR : carve_step;
        carve_a_nxt = carve_step;
        if (carve_last) begin
          chunks_nxt = chunks_r + CKW'(1);
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        slot_src  = blk_r;
        state_nxt = S_POP;
      end
      S_POP: begin
        head_we          = 1'b1;
        head_wdata       = link_rd;
        valid_nxt[cls_r] = 1'b1;
        if (tally_r != TALLY_MAX) begin
          tally_nxt = tally_r + LIVE_W'(1);
        end
        fin      = 1'b1;
        fin_addr = ADDR_W'(blk_r);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_live_nxt   = tally_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished request goes straight to the output register when it is free,
    // otherwise it is parked until the waiting result has been transferred.
    if (fin) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = fin_addr;
        out_status_nxt = fin_status;
        out_live_nxt   = tally_nxt;
        state_nxt      = S_IDLE;
      end else begin
        res_addr_nxt   = fin_addr;
        res_status_nxt = fin_status;
        state_nxt      = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      chunks_r    <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      chunks_r    <= chunks_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cls_r        <= cls_nxt;
    zero_r       <= zero_nxt;
    over_r       <= over_nxt;
    free_ok_r    <= free_ok_nxt;
    addr_r       <= addr_nxt;
    blk_r        <= blk_nxt;
    bsize_r      <= bsize_nxt;
    carve_a_r    <= carve_a_nxt;
    chunk_end_r  <= chunk_end_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_live_r   <= out_live_nxt;
  end

  a_accept_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_HEAD)
    else $error("accepted request did not move on to the head lookup");

  a_chunks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chunks_r <= CKW'(POOL_CHUNKS))
    else $error("more chunks carved than the pool holds");

  a_carve_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CARVE |-> carve_a_r < chunk_end_r)
    else $error("carving ran past the end of its chunk");

  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (tally_r == $past(tally_r)) || (tally_r == $past(tally_r) + LIVE_W'(1)) ||
             (tally_r == $past(tally_r) - LIVE_W'(1)) || (tally_r == '0))
    else $error("live block count changed by more than one block");

endmodule
`default_nettype wire
